[src/csalu_pkg.sv]
// shared types, constants and codes of the checked signed ALU
package csalu_pkg;

    localparam int DATA_WIDTH    = 64;
    localparam int HALF_WIDTH    = DATA_WIDTH / 2;
    localparam int OPERAND_WIDTH = 64;
    localparam int OP_WIDTH      = 3;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    // multiply result merges into the item at this pipeline stage
    localparam int MUL_DONE_STAGE = 2;

    typedef logic [DATA_WIDTH-1:0]    word_t;
    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [OP_WIDTH-1:0]      opcode_t;

    localparam opcode_t OP_ADD = 3'd0;
    localparam opcode_t OP_SUB = 3'd1;
    localparam opcode_t OP_MUL = 3'd2;
    localparam opcode_t OP_DIV = 3'd3;
    localparam opcode_t OP_MOD = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_DONE = 2'd0,
        KIND_MUL  = 2'd1,
        KIND_DIV  = 2'd2,
        KIND_MOD  = 2'd3
    } kind_t;

    // val holds a finished result, or the partial remainder while dividing
    // mag_a holds the dividend shifting into the quotient while dividing
    typedef struct packed {
        kind_t   kind;
        status_t status;
        logic    neg_a;
        logic    neg_b;
        word_t   val;
        word_t   mag_a;
        word_t   mag_b;
    } item_t;

endpackage

[src/checked_signed_alu_core.sv]
// top level of the overflow-checked signed ALU
// Takes one transaction per cycle while s_ready is high and returns one
// result per transaction in order. A transaction is registered in the input
// queue, then moves through the stages of the radix-2 divide pipeline that
// every transaction passes through (multiply finishes in its first three
// stages), then into the output register, which drives the m_ side. The whole
// back pipeline holds while a result waits; the four-entry queue keeps s_ready
// high until it fills. Results are computed at DATA_WIDTH bits and
// sign-extended.
module checked_signed_alu_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csalu_pkg::opcode_t  s_operation,
    input  csalu_pkg::operand_t s_left_operand,
    input  csalu_pkg::operand_t s_right_operand,
    output logic                m_valid,
    input  logic                m_ready,
    output csalu_pkg::operand_t m_result_value,
    output csalu_pkg::status_t  m_status
);
    import csalu_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  fifo_full;
    logic  head_valid;
    logic  head_pop;

    assign s_ready = !fifo_full;

    csalu_front u_front (
        .operation     (s_operation),
        .left_operand  (s_left_operand),
        .right_operand (s_right_operand),
        .item          (front_item)
    );

    csalu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && s_ready),
        .push_item  (front_item),
        .full       (fifo_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    csalu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .head_pop       (head_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

endmodule

[src/csalu_front.sv]
// front end: classifies a transaction, finishes add, subtract and error cases
module csalu_front (
    input  csalu_pkg::opcode_t  operation,
    input  csalu_pkg::operand_t left_operand,
    input  csalu_pkg::operand_t right_operand,
    output csalu_pkg::item_t    item
);
    import csalu_pkg::*;

    word_t a;
    word_t b;
    word_t sum;
    word_t dif;
    logic  a_is_min;
    logic  b_is_m1;
    logic  b_is_zero;

    assign a         = left_operand[DATA_WIDTH-1:0];
    assign b         = right_operand[DATA_WIDTH-1:0];
    assign sum       = a + b;
    assign dif       = a - b;
    assign a_is_min  = (a == {1'b1, {(DATA_WIDTH-1){1'b0}}});
    assign b_is_m1   = &b;
    assign b_is_zero = (b == '0);

    always_comb begin
        item.kind   = KIND_DONE;
        item.status = ST_OK;
        item.neg_a  = a[DATA_WIDTH-1];
        item.neg_b  = b[DATA_WIDTH-1];
        item.val    = '0;
        item.mag_a  = a[DATA_WIDTH-1] ? word_t'('0) - a : a;
        item.mag_b  = b[DATA_WIDTH-1] ? word_t'('0) - b : b;
        unique case (operation)
            OP_ADD: begin
                if ((a[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1])
                    & (b[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1])) begin
                    item.status = ST_OVERFLOW;
                end else begin
                    item.val = sum;
                end
            end
            OP_SUB: begin
                if ((a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1])
                    & (a[DATA_WIDTH-1] ^ dif[DATA_WIDTH-1])) begin
                    item.status = ST_OVERFLOW;
                end else begin
                    item.val = dif;
                end
            end
            OP_MUL: begin
                item.kind = KIND_MUL;
            end
            OP_DIV: begin
                if (b_is_zero) begin
                    item.status = ST_DIVZERO;
                end else if (a_is_min && b_is_m1) begin
                    item.status = ST_OVERFLOW;
                end else begin
                    item.kind = KIND_DIV;
                end
            end
            OP_MOD: begin
                if (b_is_zero) begin
                    item.status = ST_DIVZERO;
                end else begin
                    item.kind = KIND_MOD;
                end
            end
            default: begin
                item.status = ST_INVALID;
            end
        endcase
    end

endmodule

[src/csalu_fifo.sv]
// short queue of classified transactions between front and back end
module csalu_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  csalu_pkg::item_t  push_item,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output csalu_pkg::item_t  head_item
);
    import csalu_pkg::*;

    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

[src/csalu_back.sv]
// back end: pipelined multiply, radix-2 divide pipeline, result fixup and output register
module csalu_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  csalu_pkg::item_t    head_item,
    output logic                head_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output csalu_pkg::operand_t m_result_value,
    output csalu_pkg::status_t  m_status
);
    import csalu_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int HW = HALF_WIDTH;

    item_t           stg_reg  [DW];
    item_t           stg_next [DW];
    logic [DW-1:0]   stg_vld_reg;
    logic            adv;

    // multiply pipeline, aligned with stages 0 and 1
    word_t           p00_reg, p01_reg, p10_reg, p11_reg;
    logic [HW+1:0]   mid_reg;
    word_t           hisum_reg;
    logic [HW-1:0]   p00lo_reg;
    item_t           mul_merged;

    logic            out_valid_reg;
    operand_t        out_val_reg;
    status_t         out_st_reg;
    word_t           post_val;

    function automatic item_t div_step(item_t it);
        item_t        r;
        logic [DW:0]  t;
        r = it;
        t = {it.val, it.mag_a[DW-1]};
        if (it.kind == KIND_DIV || it.kind == KIND_MOD) begin
            if (t >= {1'b0, it.mag_b}) begin
                r.val   = word_t'(t - {1'b0, it.mag_b});
                r.mag_a = {it.mag_a[DW-2:0], 1'b1};
            end else begin
                r.val   = t[DW-1:0];
                r.mag_a = {it.mag_a[DW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    assign adv      = !out_valid_reg || m_ready;
    assign head_pop = adv && head_valid;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p00_reg   <= word_t'(head_item.mag_a[HW-1:0] * head_item.mag_b[HW-1:0]);
            p01_reg   <= word_t'(head_item.mag_a[HW-1:0] * head_item.mag_b[DW-1:HW]);
            p10_reg   <= word_t'(head_item.mag_a[DW-1:HW] * head_item.mag_b[HW-1:0]);
            p11_reg   <= word_t'(head_item.mag_a[DW-1:HW] * head_item.mag_b[DW-1:HW]);
            mid_reg   <= {2'b00, p00_reg[DW-1:HW]} + {2'b00, p01_reg[HW-1:0]}
                         + {2'b00, p10_reg[HW-1:0]};
            hisum_reg <= p11_reg + word_t'(p01_reg[DW-1:HW]) + word_t'(p10_reg[DW-1:HW]);
            p00lo_reg <= p00_reg[HW-1:0];
        end
    end

    always_comb begin
        word_t lo;
        word_t hi;
        word_t limit;
        logic  neg;
        logic  ovf;
        lo    = {mid_reg[HW-1:0], p00lo_reg};
        hi    = hisum_reg + word_t'(mid_reg[HW+1:HW]);
        neg   = stg_reg[MUL_DONE_STAGE-1].neg_a ^ stg_reg[MUL_DONE_STAGE-1].neg_b;
        limit = {1'b1, {(DW-1){1'b0}}} - word_t'(!neg);
        ovf   = (hi != '0) || (lo > limit);
        mul_merged = stg_reg[MUL_DONE_STAGE-1];
        if (mul_merged.kind == KIND_MUL) begin
            mul_merged.kind   = KIND_DONE;
            mul_merged.status = ovf ? ST_OVERFLOW : ST_OK;
            mul_merged.val    = ovf ? '0 : (neg ? word_t'('0) - lo : lo);
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign stg_next[k] = div_step(head_item);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stg_vld_reg[k] <= 1'b0;
                end else if (adv) begin
                    stg_vld_reg[k] <= head_valid;
                end
            end
        end else begin : g_rest
            if (k == MUL_DONE_STAGE) begin : g_mul
                assign stg_next[k] = div_step(mul_merged);
            end else begin : g_div
                assign stg_next[k] = div_step(stg_reg[k-1]);
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stg_vld_reg[k] <= 1'b0;
                end else if (adv) begin
                    stg_vld_reg[k] <= stg_vld_reg[k-1];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // quotient and remainder sign fixup
    always_comb begin
        item_t last;
        last = stg_reg[DW-1];
        unique case (last.kind)
            KIND_DONE: post_val = last.val;
            KIND_MUL:  post_val = last.val;
            KIND_DIV:  post_val = (last.neg_a ^ last.neg_b) ? word_t'('0) - last.mag_a
                                                            : last.mag_a;
            KIND_MOD: begin
                if (last.val == '0) begin
                    post_val = '0;
                end else if (last.neg_a == last.neg_b) begin
                    post_val = last.neg_a ? word_t'('0) - last.val : last.val;
                end else begin
                    post_val = last.neg_b ? last.val - last.mag_b : last.mag_b - last.val;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= stg_vld_reg[DW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_val_reg <= OPERAND_WIDTH'(signed'(post_val));
            out_st_reg  <= stg_reg[DW-1].status;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_val_reg;
    assign m_status       = out_st_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_result_value == '0))
        else $error("error result with nonzero value");
    a_mul_merged: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_vld_reg[DW-1] |-> (stg_reg[DW-1].kind != KIND_MUL))
        else $error("multiply reached the end unmerged");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(stg_vld_reg))
        else $error("pipeline moved during stall");

endmodule
